### rtl/rgb_to_hsv_converter_defines.svh
// Assertion macros for the RGB to HSV converter checker.
// Used by rgbhsv_checker.sv; depends on clk and rst_n in the including scope.
`ifndef RGB_TO_HSV_CONVERTER_DEFINES_SVH
`define RGB_TO_HSV_CONVERTER_DEFINES_SVH

// same-cycle implication, disabled in reset
`define RGBHSV_ASSERT_NOW(label, cond, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (conseq)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define RGBHSV_ASSERT_NEXT(label, cond, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
        else $error(msg);

`endif

### rtl/rgbhsv_pkg.sv
// Shared constants and types for the RGB to HSV converter.
// No dependencies; used by rgbhsv_div and rgb_to_hsv_converter.
`default_nettype none

package rgbhsv_pkg;

    localparam int CHAN_W     = 8;
    localparam int HUE_W      = 9;
    localparam int S_TDATA_W  = 24;
    localparam int M_TDATA_W  = 32;

    // hue numerator magnitude reaches 5*255, so 11 bits
    localparam int MAG_W      = 11;
    localparam int SNUM_W     = 12;

    // shared divider shape: 17-bit dividend, 8-bit divisor, 9-bit quotient
    localparam int DIV_DEN_W  = 8;
    localparam int DIV_QUO_W  = 9;
    localparam int DIV_NUM_W  = DIV_DEN_W + DIV_QUO_W;

    localparam int HUE_SCALE  = 60;
    localparam int SAT_SCALE  = 255;
    localparam int HUE_WRAP   = 360;

    // front stage, multiply stage, one stage per quotient bit, output stage
    localparam int N_STAGES   = DIV_QUO_W + 3;

    typedef struct packed {
        logic [CHAN_W-1:0] bright;
        logic              neg;
        logic              grey;
        logic              black;
    } side_t;

endpackage

`default_nettype wire

### rtl/rgb_to_hsv_converter.sv
// RGB to HSV converter, top level: one 24-bit pixel (8 bits per channel) in, hue/saturation/value out.
// Depends on rgbhsv_pkg and rgbhsv_div.
//
//  channel  dir  handshake          payload (low bit up)
//  s_       in   s_tvalid/s_tready  s_tdata: red[7:0] green[15:8] blue[23:16]
//  m_       out  m_tvalid/m_tready  m_tdata: hue[8:0] saturation[16:9] brightness[24:17]
//
// Stages: front compare, multiply, 9 divider steps, output fix-up.
// One item per cycle unless m_tready stalls; dividers are pipelined one quotient bit a stage.
// rst_n clears only the stage valid bits; payload registers are not reset.
// A stall on m_tready holds the output item; earlier stages keep filling bubbles,
// so s_tready only drops once every stage holds an item.
`default_nettype none

module rgb_to_hsv_converter (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [rgbhsv_pkg::S_TDATA_W-1:0]    s_tdata,  // red, green, blue
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic      [rgbhsv_pkg::M_TDATA_W-1:0]    m_tdata   // hue, saturation, brightness, pad
);

    localparam int CW = rgbhsv_pkg::CHAN_W;
    localparam int NS = rgbhsv_pkg::N_STAGES;
    localparam int QW = rgbhsv_pkg::DIV_QUO_W;
    localparam int NW = rgbhsv_pkg::DIV_NUM_W;
    localparam int DW = rgbhsv_pkg::DIV_DEN_W;
    localparam int MW = rgbhsv_pkg::MAG_W;
    localparam int SW = rgbhsv_pkg::SNUM_W;
    localparam int HW = rgbhsv_pkg::HUE_W;
    localparam int DIV0 = 2;

    logic [NS-1:0] v_reg;
    logic [NS-1:0] adv;

    // stage advances when it or any later stage is empty, or when the output is taken
    always_comb
    begin
        for (int i = 0; i < NS; i++)
        begin
            adv[i] = m_tready || (|(~v_reg >> i));
        end
    end

    assign s_tready = adv[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (adv[0])
            begin
                v_reg[0] <= s_tvalid;
            end
            for (int i = 1; i < NS; i++)
            begin
                if (adv[i])
                begin
                    v_reg[i] <= v_reg[i-1];
                end
            end
        end
    end

    // ---- front stage: max, min, sector numerator ----
    logic [CW-1:0] red, green, blue;
    logic [CW-1:0] mx_next, mn_next, dl_next;
    logic [SW-1:0] hn_next;
    logic [MW-1:0] mag_next;
    rgbhsv_pkg::side_t side0_next;

    assign red   = s_tdata[CW-1:0];
    assign green = s_tdata[2*CW-1:CW];
    assign blue  = s_tdata[3*CW-1:2*CW];

    always_comb
    begin
        mx_next = (red > green) ? red : green;
        mx_next = (mx_next > blue) ? mx_next : blue;
        mn_next = (red < green) ? red : green;
        mn_next = (mn_next < blue) ? mn_next : blue;
        dl_next = mx_next - mn_next;
        // ties: red first, then green
        if (red >= green && red >= blue)
        begin
            hn_next = SW'(green) - SW'(blue);
        end
        else if (green >= blue)
        begin
            hn_next = {3'd0, dl_next, 1'b0} + SW'(blue) - SW'(red);
        end
        else
        begin
            hn_next = {2'd0, dl_next, 2'd0} + SW'(red) - SW'(green);
        end
        side0_next.neg    = hn_next[SW-1];
        side0_next.grey   = (dl_next == '0);
        side0_next.black  = (mx_next == '0);
        side0_next.bright = mx_next;
        mag_next = hn_next[SW-1] ? MW'(-hn_next) : hn_next[MW-1:0];
    end

    logic [CW-1:0]     dl0_reg;
    logic [MW-1:0]     mag0_reg;
    rgbhsv_pkg::side_t side0_reg;

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            dl0_reg   <= dl_next;
            mag0_reg  <= mag_next;
            side0_reg <= side0_next;
        end
    end

    // ---- multiply stage ----
    logic [NW-1:0]     hnum1_reg;
    logic [NW-1:0]     snum1_reg;
    logic [DW-1:0]     hden1_reg;
    logic [DW-1:0]     sden1_reg;
    rgbhsv_pkg::side_t side1_reg;

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            hnum1_reg <= NW'(NW'(mag0_reg) * NW'(rgbhsv_pkg::HUE_SCALE));
            snum1_reg <= NW'(NW'(dl0_reg) * NW'(rgbhsv_pkg::SAT_SCALE));
            hden1_reg <= DW'(dl0_reg);
            sden1_reg <= DW'(side0_reg.bright);
            side1_reg <= side0_reg;
        end
    end

    // ---- divider stages ----
    logic [QW-1:0] hquo;
    logic [QW-1:0] squo;

    rgbhsv_div #(
        .DEN_W (DW),
        .QUO_W (QW)
    ) u_hue_div (
        .clk (clk),
        .ld  (adv[DIV0 +: QW]),
        .num (hnum1_reg),
        .den (hden1_reg),
        .quo (hquo)
    );

    rgbhsv_div #(
        .DEN_W (DW),
        .QUO_W (QW)
    ) u_sat_div (
        .clk (clk),
        .ld  (adv[DIV0 +: QW]),
        .num (snum1_reg),
        .den (sden1_reg),
        .quo (squo)
    );

    rgbhsv_pkg::side_t side_reg [QW];

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < QW; k++)
        begin
            if (adv[DIV0+k])
            begin
                side_reg[k] <= (k == 0) ? side1_reg : side_reg[(k == 0) ? 0 : k-1];
            end
        end
    end

    // ---- output stage: wrap negative hue, mask grey and black ----
    logic [HW-1:0] hue_next;
    logic [CW-1:0] sat_next;
    logic [HW-1:0] hue_reg;
    logic [CW-1:0] sat_reg;
    logic [CW-1:0] bright_reg;

    always_comb
    begin
        if (side_reg[QW-1].grey)
        begin
            hue_next = '0;
        end
        else if (side_reg[QW-1].neg && hquo != '0)
        begin
            hue_next = HW'(rgbhsv_pkg::HUE_WRAP) - hquo;
        end
        else
        begin
            hue_next = hquo;
        end
        sat_next = side_reg[QW-1].black ? '0 : squo[CW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (adv[NS-1])
        begin
            hue_reg    <= hue_next;
            sat_reg    <= sat_next;
            bright_reg <= side_reg[QW-1].bright;
        end
    end

    assign m_tvalid = v_reg[NS-1];
    assign m_tdata  = {{(rgbhsv_pkg::M_TDATA_W - HW - 2*CW){1'b0}},
                       bright_reg, sat_reg, hue_reg};

endmodule

`default_nettype wire

### rtl/rgbhsv_div.sv
// Pipelined restoring divider, one quotient bit per stage.
// Depends on rgbhsv_pkg for default widths. Dividend must give a quotient below 2**QUO_W.
`default_nettype none

module rgbhsv_div #(
    parameter int DEN_W = rgbhsv_pkg::DIV_DEN_W,
    parameter int QUO_W = rgbhsv_pkg::DIV_QUO_W
) (
    input  wire logic                     clk,
    input  wire logic [QUO_W-1:0]         ld,
    input  wire logic [DEN_W+QUO_W-1:0]   num,
    input  wire logic [DEN_W-1:0]         den,
    output logic      [QUO_W-1:0]         quo
);

    localparam int NUM_W = DEN_W + QUO_W;

    logic [DEN_W-1:0] rem_reg  [QUO_W];
    logic [DEN_W-1:0] rem_next [QUO_W];
    logic [QUO_W-1:0] low_reg  [QUO_W];
    logic [QUO_W-1:0] low_next [QUO_W];
    logic [QUO_W-1:0] quo_reg  [QUO_W];
    logic [QUO_W-1:0] quo_next [QUO_W];
    logic [DEN_W-1:0] den_reg  [QUO_W];
    logic [DEN_W-1:0] den_next [QUO_W];

    always_comb
    begin
        logic [DEN_W-1:0] r;
        logic [QUO_W-1:0] l;
        logic [QUO_W-1:0] q;
        logic [DEN_W-1:0] d;
        logic [DEN_W:0]   t;
        logic [DEN_W:0]   diff;
        for (int k = 0; k < QUO_W; k++)
        begin
            if (k == 0)
            begin
                // top bits of the dividend are already below the divisor
                r = num[NUM_W-1:QUO_W];
                l = num[QUO_W-1:0];
                q = '0;
                d = den;
            end
            else
            begin
                r = rem_reg[k-1];
                l = low_reg[k-1];
                q = quo_reg[k-1];
                d = den_reg[k-1];
            end
            t    = {r, l[QUO_W-1]};
            diff = t - {1'b0, d};
            if (t >= {1'b0, d})
            begin
                rem_next[k] = diff[DEN_W-1:0];
                quo_next[k] = {q[QUO_W-2:0], 1'b1};
            end
            else
            begin
                rem_next[k] = t[DEN_W-1:0];
                quo_next[k] = {q[QUO_W-2:0], 1'b0};
            end
            low_next[k] = {l[QUO_W-2:0], 1'b0};
            den_next[k] = d;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < QUO_W; k++)
        begin
            if (ld[k])
            begin
                rem_reg[k] <= rem_next[k];
                low_reg[k] <= low_next[k];
                quo_reg[k] <= quo_next[k];
                den_reg[k] <= den_next[k];
            end
        end
    end

    assign quo = quo_reg[QUO_W-1];

endmodule

`default_nettype wire

### rtl/rgbhsv_checker.sv
// Port-level checker for rgb_to_hsv_converter, bound to the top level.
// Depends on rgb_to_hsv_converter_defines.svh for the assertion macros.
`default_nettype none

`include "rgb_to_hsv_converter_defines.svh"

module rgbhsv_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata
);

    // a stalled output item holds
    `RGBHSV_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "output item changed under stall")

    // hue always wraps into 0..359
    `RGBHSV_ASSERT_NOW(a_hue_range, m_tvalid, m_tdata[8:0] < 9'd360, "hue out of range")

    // a black pixel has no hue and no saturation
    `RGBHSV_ASSERT_NOW(a_black, m_tvalid && m_tdata[24:17] == 8'd0, m_tdata[16:0] == 17'd0, "black pixel with hue or saturation")

    // padding stays clear
    `RGBHSV_ASSERT_NOW(a_pad, m_tvalid, m_tdata[31:25] == 7'd0, "padding bits set")

    // no back-pressure reaches the input while the output drains
    `RGBHSV_ASSERT_NOW(a_no_stall, m_tready, s_tready, "input stalled while output ready")

endmodule

bind rgb_to_hsv_converter rgbhsv_checker u_rgbhsv_checker (.*);

`default_nettype wire
